[rtl/kmeans_clustering_unit_assert.svh]
`ifndef KMEANS_CLUSTERING_UNIT_ASSERT_SVH
`define KMEANS_CLUSTERING_UNIT_ASSERT_SVH
// clocked assertion under active-low async reset
`define KMC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// same, with a next-cycle implication
`define KMC_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);
`endif

[rtl/kmc_pkg.sv]
`default_nettype none
package kmc_pkg;
	localparam int COORD_W = 24;
	localparam int CFG_W = 5;
	localparam int IDX_W = 4;
	typedef logic signed [COORD_W-1:0] coord_t;
	typedef struct packed {
		coord_t x;
		coord_t y;
		coord_t z;
	} point_t;
	typedef struct packed {
		logic start;
		logic busy;
	} div_ctl_t;
endpackage
`default_nettype wire

[rtl/kmc_if.sv]
`default_nettype none
interface kmc_point_if import kmc_pkg::*; ();
	logic valid;
	logic ready;
	coord_t point_x;
	coord_t point_y;
	coord_t point_z;
	logic last_point;
	modport source (output valid, point_x, point_y, point_z, last_point, input ready);
	modport sink (input valid, point_x, point_y, point_z, last_point, output ready);
endinterface

interface kmc_centroid_if import kmc_pkg::*; ();
	logic valid;
	logic ready;
	logic [IDX_W-1:0] centroid_index;
	coord_t centroid_x;
	coord_t centroid_y;
	coord_t centroid_z;
	logic last_centroid;
	logic overflow;
	modport source (output valid, centroid_index, centroid_x, centroid_y, centroid_z,
		last_centroid, overflow, input ready);
	modport sink (input valid, centroid_index, centroid_x, centroid_y, centroid_z,
		last_centroid, overflow, output ready);
endinterface

interface kmc_cfg_if import kmc_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_W-1:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

[rtl/kmc_div.sv]
`default_nettype none
// Signed restoring divider, one quotient bit per cycle, truncates toward zero.
module kmc_div import kmc_pkg::*; #(
	parameter int NUM_W = 34,
	parameter int DEN_W = 11
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic signed [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0] den,
	output logic busy,
	output logic done,
	output coord_t quot
);
	localparam int CNT_W = $clog2(NUM_W + 1);
	logic [NUM_W-1:0] mag_q;
	logic [NUM_W-1:0] q_q;
	logic [DEN_W:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic neg_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W:0] trial;
	logic [NUM_W-1:0] q_fix;

	assign trial = {rem_q[DEN_W-1:0], mag_q[NUM_W-1]};
	assign q_fix = neg_q ? (~q_q + 1'b1) : q_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy <= 1'b1;
				cnt_q <= CNT_W'(NUM_W);
				mag_q <= num[NUM_W-1] ? (~num + 1'b1) : num;
				neg_q <= num[NUM_W-1];
				den_q <= den;
				rem_q <= '0;
				q_q <= '0;
			end else if (busy) begin
				mag_q <= {mag_q[NUM_W-2:0], 1'b0};
				if (trial >= {1'b0, den_q}) begin
					rem_q <= trial - {1'b0, den_q};
					q_q <= {q_q[NUM_W-2:0], 1'b1};
				end else begin
					rem_q <= trial;
					q_q <= {q_q[NUM_W-2:0], 1'b0};
				end
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	assign quot = (den_q == '0) ? '0 : coord_t'(q_fix[COORD_W-1:0]);
endmodule
`default_nettype wire

[rtl/kmeans_clustering_unit.sv]
// channel    dir  handshake      payload
// pts        in   valid/ready    point_x/y/z, last_point
// cents      out  valid/ready    centroid_index, centroid_x/y/z, last_centroid, overflow
// cfg        in   valid/ready    data = cluster_count
// Points load at one item per cycle into the point memory.
// After the last point: seed the centroids from the points, then k+2 passes; each pass
// clears the sums, then per point does a point read, then a centroid read and a compare
// per centroid, then adds the point to its nearest centroid; then serial division.
// Each result is read in OUT_RD and presented in OUT_V; a stall holds the result.
// Reset clears control only; the memories need no clearing.
`default_nettype none
module kmeans_clustering_unit import kmc_pkg::*; #(
	parameter int MAX_POINTS = 1024,
	parameter int MAX_CLUSTERS = 16
) (
	input wire logic clk,
	input wire logic arst_n,
	kmc_point_if.sink pts,
	kmc_centroid_if.source cents,
	kmc_cfg_if.sink cfg
);
	localparam int PA_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int PN_W = $clog2(MAX_POINTS + 1);
	localparam int CA_W = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
	localparam int CN_W = $clog2(MAX_CLUSTERS + 1);
	localparam int IT_W = $clog2(MAX_CLUSTERS + 3);
	localparam int SUM_W = COORD_W + PN_W;
	localparam int D_W = 2 * COORD_W + 4;

	typedef enum logic [3:0] {
		LOAD, SEED, CLR, RD_P, RD_C, DIST, UPD, DIV_RD, DIV_GO, DIV_WT, OUT_RD, OUT_V
	} st_t;
	st_t st_q;

	point_t pmem [MAX_POINTS];
	point_t cmem [MAX_CLUSTERS];
	logic signed [SUM_W-1:0] sx_q [MAX_CLUSTERS];
	logic signed [SUM_W-1:0] sy_q [MAX_CLUSTERS];
	logic signed [SUM_W-1:0] sz_q [MAX_CLUSTERS];
	logic [PN_W-1:0] mc_q [MAX_CLUSTERS];

	logic [CFG_W-1:0] k_cfg_q;
	logic [CN_W-1:0] k_q;
	logic [PN_W-1:0] n_q;
	logic drop_q;
	logic [PN_W-1:0] p_q;
	logic [CN_W-1:0] c_q;
	logic [IT_W-1:0] it_q;
	logic [1:0] ax_q;
	point_t prd_q, pt_q, crd_q;
	logic [CA_W-1:0] best_q;
	logic [D_W-1:0] bestd_q;
	logic signed [SUM_W-1:0] dnum;
	logic dstart, dbusy, ddone;
	coord_t dq;
	coord_t nx_q, ny_q;
	logic [PN_W-1:0] sd_q;
	logic [D_W-1:0] sqd;
	logic signed [COORD_W:0] ddx, ddy, ddz;
	logic [2*COORD_W+1:0] sqx, sqy, sqz;
	logic [CN_W-1:0] kc;

	assign kc = (k_cfg_q == '0) ? CN_W'(1) :
		(32'(k_cfg_q) > MAX_CLUSTERS) ? CN_W'(MAX_CLUSTERS) : CN_W'(k_cfg_q);

	assign pts.ready = (st_q == LOAD);
	assign cfg.ready = 1'b1;

	// squared distance from the point register to the centroid register
	assign ddx = {pt_q.x[COORD_W-1], pt_q.x} - {crd_q.x[COORD_W-1], crd_q.x};
	assign ddy = {pt_q.y[COORD_W-1], pt_q.y} - {crd_q.y[COORD_W-1], crd_q.y};
	assign ddz = {pt_q.z[COORD_W-1], pt_q.z} - {crd_q.z[COORD_W-1], crd_q.z};
	assign sqx = ddx * ddx;
	assign sqy = ddy * ddy;
	assign sqz = ddz * ddz;
	assign sqd = D_W'(sqx) + D_W'(sqy) + D_W'(sqz);

	always_comb begin
		unique case (ax_q)
			2'd0: dnum = sx_q[c_q[CA_W-1:0]];
			2'd1: dnum = sy_q[c_q[CA_W-1:0]];
			default: dnum = sz_q[c_q[CA_W-1:0]];
		endcase
	end
	assign dstart = (st_q == DIV_GO);

	kmc_div #(.NUM_W(SUM_W), .DEN_W(PN_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dstart), .num(dnum),
		.den(mc_q[c_q[CA_W-1:0]]), .busy(dbusy), .done(ddone), .quot(dq)
	);

	always_ff @(posedge clk) begin
		if (pts.valid && pts.ready && 32'(n_q) < MAX_POINTS)
			pmem[n_q[PA_W-1:0]] <= '{pts.point_x, pts.point_y, pts.point_z};
		prd_q <= pmem[(st_q == SEED) ? sd_q[PA_W-1:0] : p_q[PA_W-1:0]];
		crd_q <= cmem[c_q[CA_W-1:0]];
		// point read issued in RD_P is valid from RD_C on
		if (st_q == RD_C) pt_q <= prd_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= LOAD;
			k_cfg_q <= CFG_W'(1);
			n_q <= '0;
			drop_q <= 1'b0;
			cents.valid <= 1'b0;
			p_q <= '0;
			c_q <= '0;
			it_q <= '0;
			ax_q <= '0;
			sd_q <= '0;
		end else begin
			if (cfg.valid) k_cfg_q <= cfg.data;
			unique case (st_q)
				LOAD: if (pts.valid) begin
					if (32'(n_q) < MAX_POINTS) n_q <= n_q + 1'b1;
					else drop_q <= 1'b1;
					if (pts.last_point) begin
						k_q <= kc;
						c_q <= '0;
						ax_q <= '0;
						sd_q <= '0;
						st_q <= SEED;
					end
				end
				SEED: begin
					// prd_q holds the previous cycle's read: write entry c-1; seed index walks c mod n
					ax_q <= 2'd1;
					sd_q <= (sd_q + 1'b1 == n_q) ? '0 : sd_q + 1'b1;
					if (ax_q != 0) cmem[CA_W'(c_q - 1'b1)] <= prd_q;
					if (c_q == k_q) begin
						it_q <= '0;
						st_q <= CLR;
					end else c_q <= c_q + 1'b1;
				end
				CLR: begin
					for (int i = 0; i < MAX_CLUSTERS; i++) begin
						sx_q[i] <= '0;
						sy_q[i] <= '0;
						sz_q[i] <= '0;
						mc_q[i] <= '0;
					end
					p_q <= '0;
					st_q <= RD_P;
				end
				RD_P: begin
					c_q <= '0;
					st_q <= RD_C;
				end
				RD_C: st_q <= DIST;
				DIST: begin
					if (c_q == '0 || sqd < bestd_q) begin
						bestd_q <= sqd;
						best_q <= c_q[CA_W-1:0];
					end
					if (c_q + 1'b1 == k_q) st_q <= UPD;
					else begin
						c_q <= c_q + 1'b1;
						st_q <= RD_C;
					end
				end
				UPD: begin
					sx_q[best_q] <= sx_q[best_q] + SUM_W'(pt_q.x);
					sy_q[best_q] <= sy_q[best_q] + SUM_W'(pt_q.y);
					sz_q[best_q] <= sz_q[best_q] + SUM_W'(pt_q.z);
					mc_q[best_q] <= mc_q[best_q] + 1'b1;
					if (p_q + 1'b1 == n_q) begin
						c_q <= '0;
						ax_q <= '0;
						st_q <= DIV_GO;
					end else begin
						p_q <= p_q + 1'b1;
						st_q <= RD_P;
					end
				end
				DIV_RD: st_q <= DIV_GO;
				DIV_GO: st_q <= DIV_WT;
				DIV_WT: if (ddone) begin
					unique case (ax_q)
						2'd0: begin nx_q <= dq; ax_q <= 2'd1; st_q <= DIV_GO; end
						2'd1: begin ny_q <= dq; ax_q <= 2'd2; st_q <= DIV_GO; end
						default: begin
							cmem[c_q[CA_W-1:0]] <= '{nx_q, ny_q, dq};
							ax_q <= '0;
							if (c_q + 1'b1 == k_q) begin
								c_q <= '0;
								if (32'(it_q) + 1 == 32'(k_q) + 2) st_q <= OUT_RD;
								else begin
									it_q <= it_q + 1'b1;
									st_q <= CLR;
								end
							end else begin
								c_q <= c_q + 1'b1;
								st_q <= DIV_GO;
							end
						end
					endcase
				end
				OUT_RD: st_q <= OUT_V;
				OUT_V: begin
					if (!cents.valid) begin
						cents.valid <= 1'b1;
						cents.centroid_index <= IDX_W'(c_q);
						cents.centroid_x <= crd_q.x;
						cents.centroid_y <= crd_q.y;
						cents.centroid_z <= crd_q.z;
						cents.last_centroid <= (c_q + 1'b1 == k_q);
						cents.overflow <= drop_q;
					end else if (cents.ready) begin
						cents.valid <= 1'b0;
						if (c_q + 1'b1 == k_q) begin
							n_q <= '0;
							drop_q <= 1'b0;
							st_q <= LOAD;
						end else begin
							c_q <= c_q + 1'b1;
							st_q <= OUT_RD;
						end
					end
				end
				default: st_q <= LOAD;
			endcase
		end
	end

`include "kmeans_clustering_unit_assert.svh"
	`KMC_ASSERT(a_no_load_busy, !(pts.ready && cents.valid), "result while loading")
	`KMC_ASSERT_NEXT(a_out_hold, cents.valid && !cents.ready, cents.valid, "result lost")
	`KMC_ASSERT(a_div_only_wait, !dbusy || st_q == DIV_WT, "divider busy out of place")
endmodule
`default_nettype wire
